// ----- rtl/core/nca_pkg.sv -----
`default_nettype none
package nca_pkg;

  localparam int unsigned ENTRIES = 16;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SUM_W = (CNT_W > 5) ? CNT_W : 5;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned LIFE_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADARG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS   = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_LOOKUP,
    OP_TICK,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic              valid;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [LIFE_W-1:0] life;
  } entry_t;

  typedef struct packed {
    op_e               op;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [LIFE_W-1:0] life;
    logic [LIFE_W-1:0] elapsed;
  } req_t;

  typedef struct packed {
    logic hit;
    logic free;
  } head_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/neighbor_cache_with_aging_top.sv -----
// neighbor cache with lifetime aging
//
// input channel: in_valid_i / in_stall_o with kind_i, ip_addr_i, mac_in_i,
// lifetime_secs_i, elapsed_secs_i. kind 0 puts an entry, 1 looks up an
// address, 2 ages all entries by elapsed_secs_i.
// output channel: out_valid_o / out_stall_i with status_o, mac_out_o and
// entry_count_o, one result word for every input word.
//
// the entries sit in a ring of cells that rotates by one slot per cycle
// past a single update unit while a word runs, so each word passes an
// accept step, one full turn of the ring and a finish step, which
// registers the result. the block takes no new word until it is idle.
// a new word is accepted while the previous result still waits in the
// output register; the finish of that next word waits until the result is
// taken, so a stalled receiver holds the block after at most one word.
// reset empties the cache at once and leaves both channels idle.
`default_nettype none
module neighbor_cache_with_aging_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [nca_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [nca_pkg::IP_W-1:0]      ip_addr_i,
  input  wire logic [nca_pkg::MAC_W-1:0]     mac_in_i,
  input  wire logic [nca_pkg::LIFE_W-1:0]    lifetime_secs_i,
  input  wire logic [nca_pkg::LIFE_W-1:0]    elapsed_secs_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [nca_pkg::STAT_W-1:0]         status_o,
  output logic [nca_pkg::MAC_W-1:0]          mac_out_o,
  output logic [nca_pkg::COUNT_W-1:0]        entry_count_o
);
  import nca_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic             bad_q, bad_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] vcnt_q, vcnt_d;
  logic             matched_q, matched_d;
  logic             have_free_q, have_free_d;
  logic [IDX_W-1:0] free_slot_q, free_slot_d;
  logic [MAC_W-1:0] mac_hit_q, mac_hit_d;

  logic                out_valid_q, out_valid_d;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [MAC_W-1:0]    mac_out_q, mac_out_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic       accept;
  logic       shift_en;
  logic       finish;
  logic       fill;
  logic       last;
  entry_t     head_new;
  head_stat_t head_stat;
  entry_t     fill_entry;
  entry_t     cell_q [ENTRIES];
  logic [SUM_W-1:0] fin_cnt;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign shift_en   = (state_q == S_RUN);
  assign last       = (cnt_q == CNT_W'(ENTRIES - 1));
  assign finish     = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign fill       = finish && (req_q.op == OP_PUT) && !matched_q && have_free_q;

  assign fill_entry.valid = 1'b1;
  assign fill_entry.ip    = req_q.ip;
  assign fill_entry.mac   = req_q.mac;
  assign fill_entry.life  = req_q.life;

  nca_head u_head (
    .req_i     (req_q),
    .entry_i   (cell_q[0]),
    .matched_i (matched_q),
    .entry_o   (head_new),
    .stat_o    (head_stat)
  );

  // ring: each cell takes its upper neighbor, the last cell takes the head result
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    entry_t nb;
    if (k == ENTRIES - 1) begin : g_tail
      assign nb = head_new;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    nca_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .shift_i    (nb),
      .wr_en_i    (fill && (free_slot_q == IDX_W'(k))),
      .wr_i       (fill_entry),
      .entry_o    (cell_q[k])
    );
  end

  // decode the word at accept
  always_comb begin
    req_d.ip      = ip_addr_i;
    req_d.mac     = mac_in_i;
    req_d.life    = lifetime_secs_i;
    req_d.elapsed = elapsed_secs_i;
    req_d.op      = OP_NONE;
    bad_d         = 1'b0;
    case (kind_i)
      KIND_PUT: begin
        if (ip_addr_i == '0 || lifetime_secs_i == '0) begin
          bad_d = 1'b1;
        end else begin
          req_d.op = OP_PUT;
        end
      end
      KIND_LOOKUP: begin
        if (ip_addr_i == '0) begin
          bad_d = 1'b1;
        end else begin
          req_d.op = OP_LOOKUP;
        end
      end
      KIND_TICK: begin
        if (elapsed_secs_i != '0) begin
          req_d.op = OP_TICK;
        end
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    vcnt_d      = vcnt_q;
    matched_d   = matched_q;
    have_free_d = have_free_q;
    free_slot_d = free_slot_q;
    mac_hit_d   = mac_hit_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_RUN;
          cnt_d       = '0;
          vcnt_d      = '0;
          matched_d   = 1'b0;
          have_free_d = 1'b0;
          free_slot_d = '0;
        end
      end
      S_RUN: begin
        vcnt_d = vcnt_q + CNT_W'(head_new.valid);
        if (head_stat.hit) begin
          matched_d = 1'b1;
          mac_hit_d = cell_q[0].mac;
        end
        if (!have_free_q && head_stat.free) begin
          have_free_d = 1'b1;
          free_slot_d = cnt_q[IDX_W-1:0];
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fin_cnt = SUM_W'(vcnt_q) + SUM_W'(fill);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    mac_out_d   = mac_out_q;
    count_d     = count_q;
    if (finish) begin
      out_valid_d = 1'b1;
      mac_out_d   = '0;
      count_d     = (fin_cnt > SUM_W'(COUNT_MAX)) ? COUNT_MAX : fin_cnt[COUNT_W-1:0];
      if (bad_q) begin
        status_d = STAT_BADARG;
      end else if (req_q.op == OP_PUT) begin
        status_d = (matched_q || have_free_q) ? STAT_OK : STAT_FULL;
      end else if (req_q.op == OP_LOOKUP) begin
        status_d = matched_q ? STAT_OK : STAT_MISS;
        if (matched_q) begin
          mac_out_d = mac_hit_q;
        end
      end else begin
        status_d = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
      bad_q <= bad_d;
    end
    cnt_q       <= cnt_d;
    vcnt_q      <= vcnt_d;
    matched_q   <= matched_d;
    have_free_q <= have_free_d;
    free_slot_q <= free_slot_d;
    mac_hit_q   <= mac_hit_d;
    status_q    <= status_d;
    mac_out_q   <= mac_out_d;
    count_q     <= count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign mac_out_o     = mac_out_q;
  assign entry_count_o = count_q;

endmodule
`default_nettype wire

// ----- rtl/core/nca_cell.sv -----
`default_nettype none
module nca_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_en_i,
  input  wire nca_pkg::entry_t shift_i,
  input  wire logic            wr_en_i,
  input  wire nca_pkg::entry_t wr_i,
  output nca_pkg::entry_t      entry_o
);
  import nca_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_en_i) begin
      entry_q <= wr_i;
    end else if (shift_en_i) begin
      entry_q <= shift_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ----- rtl/core/nca_head.sv -----
`default_nettype none
module nca_head (
  input  wire nca_pkg::req_t   req_i,
  input  wire nca_pkg::entry_t entry_i,
  input  wire logic            matched_i,
  output nca_pkg::entry_t      entry_o,
  output nca_pkg::head_stat_t  stat_o
);
  import nca_pkg::*;

  logic ip_eq;

  assign ip_eq = entry_i.valid && (entry_i.ip == req_i.ip);

  always_comb begin
    entry_o     = entry_i;
    stat_o.hit  = 1'b0;
    stat_o.free = !entry_i.valid;
    case (req_i.op)
      OP_PUT: begin
        if (!matched_i && ip_eq) begin
          entry_o.mac  = req_i.mac;
          entry_o.life = req_i.life;
          stat_o.hit   = 1'b1;
        end
      end
      OP_LOOKUP: begin
        stat_o.hit = !matched_i && ip_eq && (entry_i.life != '0);
      end
      OP_TICK: begin
        if (entry_i.valid) begin
          if (entry_i.life <= req_i.elapsed) begin
            entry_o = '0;
          end else begin
            entry_o.life = entry_i.life - req_i.elapsed;
          end
        end
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import nca_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned WORDS_PER_PHASE = 406;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 4;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [MAC_W-1:0]   mac;
    logic [COUNT_W-1:0] count;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [IP_W-1:0]     ip_addr_i = '0;
  logic [MAC_W-1:0]    mac_in_i = '0;
  logic [LIFE_W-1:0]   lifetime_secs_i = '0;
  logic [LIFE_W-1:0]   elapsed_secs_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [MAC_W-1:0]    mac_out_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // shadow copy of the cache contents
  logic                cache_valid [ENTRIES];
  logic [IP_W-1:0]     cache_ip    [ENTRIES];
  logic [MAC_W-1:0]    cache_mac   [ENTRIES];
  logic [LIFE_W-1:0]   cache_life  [ENTRIES];

  result_t             pending_results [$];
  result_t             oldest;
  logic [IP_W-1:0]     ip_pool [POOL_SIZE];
  int unsigned         src_idle_pct = 0;
  int unsigned         sink_stall_pct = 0;
  int unsigned         mismatches = 0;

  neighbor_cache_with_aging_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .ip_addr_i      (ip_addr_i),
    .mac_in_i       (mac_in_i),
    .lifetime_secs_i(lifetime_secs_i),
    .elapsed_secs_i (elapsed_secs_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .mac_out_o      (mac_out_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // applies one word to the shadow cache and returns the result it should give
  function automatic result_t cache_step(input logic [KIND_W-1:0] kind,
                                         input logic [IP_W-1:0] ip,
                                         input logic [MAC_W-1:0] mac,
                                         input logic [LIFE_W-1:0] life,
                                         input logic [LIFE_W-1:0] elapsed);
    result_t r;
    int      hit;
    int      free_slot;
    int      live;
    r.status  = STAT_OK;
    r.mac     = '0;
    hit       = -1;
    free_slot = -1;
    live      = 0;
    case (kind)
      KIND_PUT: begin
        if (ip == '0 || life == '0) begin
          r.status = STAT_BADARG;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && cache_valid[i] && cache_ip[i] == ip) hit = i;
            if (free_slot < 0 && !cache_valid[i]) free_slot = i;
          end
          if (hit >= 0) begin
            cache_mac[hit]  = mac;
            cache_life[hit] = life;
          end else if (free_slot < 0) begin
            r.status = STAT_FULL;
          end else begin
            cache_valid[free_slot] = 1'b1;
            cache_ip[free_slot]    = ip;
            cache_mac[free_slot]   = mac;
            cache_life[free_slot]  = life;
          end
        end
      end
      KIND_LOOKUP: begin
        if (ip == '0) begin
          r.status = STAT_BADARG;
        end else begin
          r.status = STAT_MISS;
          for (int i = 0; i < ENTRIES; i++) begin
            if (r.status == STAT_MISS && cache_valid[i] && cache_ip[i] == ip &&
                cache_life[i] != '0) begin
              r.status = STAT_OK;
              r.mac    = cache_mac[i];
            end
          end
        end
      end
      KIND_TICK: begin
        if (elapsed != '0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i]) begin
              if (cache_life[i] <= elapsed) begin
                cache_valid[i] = 1'b0;
                cache_ip[i]    = '0;
                cache_mac[i]   = '0;
                cache_life[i]  = '0;
              end else begin
                cache_life[i] = cache_life[i] - elapsed;
              end
            end
          end
        end
      end
      default: begin
        r.status = STAT_BADARG;
      end
    endcase
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_valid[i]) live++;
    end
    r.count = (live > COUNT_MAX) ? COUNT_MAX : live[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac,
                           input logic [LIFE_W-1:0] life,
                           input logic [LIFE_W-1:0] elapsed);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    ip_addr_i       <= ip;
    mac_in_i        <= mac;
    lifetime_secs_i <= life;
    elapsed_secs_i  <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(cache_step(kind, ip, mac, life, elapsed));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word status=%0d mac=%h count=%0d",
                 $time, status_o, mac_out_o, entry_count_o);
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, oldest.status, status_o);
        end
        if (mac_out_o !== oldest.mac) begin
          mismatches++;
          $display("%0t: mac expected %h got %h", $time, oldest.mac, mac_out_o);
        end
        if (entry_count_o !== oldest.count) begin
          mismatches++;
          $display("%0t: count expected %0d got %0d", $time, oldest.count, entry_count_o);
        end
      end
    end
  end

  task automatic test_bad_arguments();
    send_word(KIND_PUT, '0, {16'($urandom), $urandom}, 32'd5, '0);
    send_word(KIND_PUT, 32'h0A00_0001, {16'($urandom), $urandom}, '0, '0);
    send_word(KIND_LOOKUP, '0, '0, '0, '0);
    send_word(KIND_LOOKUP, 32'h0A00_0001, '0, '0, '0);
    send_word(KIND_UNUSED, '1, '1, '1, '1);
  endtask

  task automatic test_fill_and_refresh();
    for (int k = 0; k < ENTRIES - 1; k++)
      send_word(KIND_PUT, 32'h0A00_0001 + k, {16'($urandom), $urandom}, k + 1, '0);
    send_word(KIND_PUT, '1, '1, '1, '0);
    // no free slot left
    send_word(KIND_PUT, 32'h0A00_00FF, {16'($urandom), $urandom}, 32'd9, '0);
    send_word(KIND_TICK, '0, '0, '0, '0);
    send_word(KIND_PUT, 32'h0A00_0004, {16'($urandom), $urandom}, 32'd100, '0);
    send_word(KIND_LOOKUP, '1, '0, '0, '0);
  endtask

  task automatic test_aging();
    send_word(KIND_TICK, '0, '0, '0, 32'd1);
    // every lifetime is at most the elapsed time, so the table empties
    send_word(KIND_TICK, '0, '0, '0, '1);
    send_word(KIND_LOOKUP, 32'h0A00_0004, '0, '0, '0);
  endtask

  task automatic random_traffic(input int unsigned words);
    int unsigned         r;
    logic [KIND_W-1:0]   kind;
    logic [IP_W-1:0]     ip;
    logic [LIFE_W-1:0]   life;
    logic [LIFE_W-1:0]   elapsed;
    repeat (words) begin
      r = $urandom_range(99);
      if (r < 48) kind = KIND_PUT;
      else if (r < 83) kind = KIND_LOOKUP;
      else if (r < 97) kind = KIND_TICK;
      else kind = KIND_UNUSED;
      r = $urandom_range(99);
      if (r < 5) ip = '0;
      else if (r < 10) ip = $urandom;
      else ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
      r = $urandom_range(99);
      if (r < 3) life = '0;
      else if (r < 8) life = $urandom;
      else life = $urandom_range(60, 1);
      r = $urandom_range(99);
      if (r < 10) elapsed = '0;
      else if (r < 15) elapsed = $urandom;
      else elapsed = $urandom_range(20, 1);
      send_word(kind, ip, {16'($urandom), $urandom}, life, elapsed);
    end
  endtask

  task automatic test_random_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_traffic(WORDS_PER_PHASE);
  endtask

  task automatic test_random_sender_gaps();
    src_idle_pct   = 45;
    sink_stall_pct = 0;
    random_traffic(WORDS_PER_PHASE);
  endtask

  task automatic test_random_receiver_stalls();
    src_idle_pct   = 0;
    sink_stall_pct = 45;
    random_traffic(WORDS_PER_PHASE);
  endtask

  task automatic test_random_both_idle();
    src_idle_pct   = 19;
    sink_stall_pct = 19;
    random_traffic(WORDS_PER_PHASE);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
      cache_life[i]  = '0;
    end
    foreach (ip_pool[k]) begin
      ip_pool[k] = $urandom;
      if (ip_pool[k] == '0) ip_pool[k] = 32'd1;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bad_arguments();
    test_fill_and_refresh();
    test_aging();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
